### design/acl_pkg.sv
// shared constants, command codes and types for the batched five-tuple acl
// no dependencies
`default_nettype none

package acl_pkg;

   // table geometry: the rule index field reaches 256 entries at most
   localparam int RULE_COUNT  = 256;
   localparam int BATCH_SLOTS = 4;
   localparam int INDEX_SPAN  = 256;
   localparam int TABLE_DEPTH = (RULE_COUNT < INDEX_SPAN) ? RULE_COUNT : INDEX_SPAN;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // key widths of the two rule stores
   localparam int ADDR_KEY_W = 64;
   localparam int PP_KEY_W   = 40;

   // protocol numbers and the all-drop verdict
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] ALL_DROP_WORD = 16'h1111;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_CLEAR = 3'd2;
   localparam logic [2:0] CMD_SCAN  = 3'd3;
   localparam logic [2:0] CMD_FAIL  = 3'd4;

   typedef struct packed {
      logic [2:0]            op;
      logic                  last;
      logic [1:0]            slot;
      logic [ADDR_W-1:0]     index;
      logic [ADDR_KEY_W-1:0] addr_key;
      logic [PP_KEY_W-1:0]   pp_key;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

### design/acl_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module acl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/acl_front.sv
// front end: classifies an incoming item into a back-end command
// depends on acl_pkg
`default_nettype none

module acl_front (
   input  logic             req_kind,
   input  logic [7:0]       req_rule_index,
   input  logic             req_rule_enable,
   input  logic [1:0]       req_slot,
   input  logic             req_last_of_batch,
   input  logic             req_header_complete,
   input  logic [31:0]      req_source_address,
   input  logic [31:0]      req_dest_address,
   input  logic [7:0]       req_protocol,
   input  logic [15:0]      req_source_port,
   input  logic [15:0]      req_dest_port,
   output acl_pkg::cmd_type cmd
);

   import acl_pkg::*;

   logic index_in_table;
   logic slot_in_batch;
   logic header_ok;

   // range checks and parse check
   always_comb begin
      index_in_table = {1'b0, req_rule_index} < 9'(TABLE_DEPTH);
      slot_in_batch  = {1'b0, req_slot} < 3'(BATCH_SLOTS);
      header_ok      = req_header_complete &&
                       (req_protocol == PROTO_TCP || req_protocol == PROTO_UDP);
   end

   // build the command; rule writes never close a batch
   always_comb begin
      cmd.addr_key = {req_source_address, req_dest_address};
      cmd.pp_key   = {req_source_port, req_dest_port, req_protocol};
      cmd.index    = req_rule_index[ADDR_W-1:0];
      cmd.slot     = req_slot;
      cmd.last     = req_kind & req_last_of_batch;
      if (!req_kind) begin
         if (!index_in_table) begin
            cmd.op = CMD_NONE;
         end else if (req_rule_enable) begin
            cmd.op = CMD_WRITE;
         end else begin
            cmd.op = CMD_CLEAR;
         end
      end else if (!slot_in_batch) begin
         cmd.op = CMD_NONE;
      end else if (!header_ok) begin
         cmd.op = CMD_FAIL;
      end else begin
         cmd.op = CMD_SCAN;
      end
   end

endmodule

`default_nettype wire

### design/acl_queue.sv
// short command queue decoupling the front end from the back end
// depends on acl_pkg
`default_nettype none

module acl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  acl_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output acl_pkg::cmd_type          head_cmd,
   output acl_pkg::queue_status_type status
);

   import acl_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   // status
   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### design/acl_back.sv
// back end: rule table, sequential rule scan, batch state and result register
// depends on acl_pkg and acl_ram
`default_nettype none

module acl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  acl_pkg::cmd_type          head_cmd,
   input  acl_pkg::queue_status_type q_status,
   output logic                      q_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic [15:0]               rsp_verdict_word,
   output logic                      rsp_batch_failed
);

   import acl_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   cmd_type                cur_ff, cur_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   hit_ff, hit_in;
   logic [BATCH_SLOTS-1:0] drop_ff, drop_in;
   logic                   bad_ff, bad_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            rsp_word_ff, rsp_word_in;
   logic                   rsp_failed_ff, rsp_failed_in;

   logic                   ram_wr;
   logic                   ram_rd;
   logic [ADDR_KEY_W-1:0]  addr_q;
   logic [PP_KEY_W-1:0]    pp_q;
   logic                   out_free;
   logic                   emit;
   logic                   emit_bad;
   logic [BATCH_SLOTS-1:0] emit_drops;
   logic [BATCH_SLOTS-1:0] merged_drops;

   // spread per-slot drop marks into verdict nibbles
   function automatic logic [15:0] verdict_of(input logic [BATCH_SLOTS-1:0] drops);
      logic [15:0] word;
      word = '0;
      for (int s = 0; s < BATCH_SLOTS; s++) begin
         word[4*s] = drops[s];
      end
      return word;
   endfunction

   // rule stores, read at the scan pointer
   acl_ram #(.WIDTH(ADDR_KEY_W), .DEPTH(TABLE_DEPTH)) u_addr_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (head_cmd.index),
      .wr_data (head_cmd.addr_key),
      .rd_en   (ram_rd),
      .rd_addr (ptr_ff),
      .rd_data (addr_q)
   );

   acl_ram #(.WIDTH(PP_KEY_W), .DEPTH(TABLE_DEPTH)) u_pp_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (head_cmd.index),
      .wr_data (head_cmd.pp_key),
      .rd_en   (ram_rd),
      .rd_addr (ptr_ff),
      .rd_data (pp_q)
   );

   // current packet's drop mark merged into the batch
   always_comb begin
      merged_drops = drop_ff;
      for (int s = 0; s < BATCH_SLOTS; s++) begin
         if (hit_ff && cur_ff.slot == 2'(s)) begin
            merged_drops[s] = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_pop;
      state_in      = state_ff;
      cur_in        = cur_ff;
      ptr_in        = ptr_ff;
      rd_pend_in    = 1'b0;
      rd_valid_in   = rd_valid_ff;
      hit_in        = hit_ff;
      drop_in       = drop_ff;
      bad_in        = bad_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_word_in   = rsp_word_ff;
      rsp_failed_in = rsp_failed_ff;
      q_pop         = 1'b0;
      ram_wr        = 1'b0;
      ram_rd        = 1'b0;
      emit          = 1'b0;
      emit_bad      = bad_ff;
      emit_drops    = drop_ff;

      // compare the entry read in the previous cycle
      if (rd_pend_ff && rd_valid_ff && addr_q == cur_ff.addr_key &&
          pp_q == cur_ff.pp_key) begin
         hit_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (head_cmd.op == CMD_SCAN) begin
                  cur_in   = head_cmd;
                  q_pop    = 1'b1;
                  ptr_in   = '0;
                  hit_in   = 1'b0;
                  state_in = ST_SCAN;
               end else if (!head_cmd.last || out_free) begin
                  q_pop = 1'b1;
                  case (head_cmd.op)
                     CMD_WRITE: begin
                        ram_wr                   = 1'b1;
                        valid_in[head_cmd.index] = 1'b1;
                     end
                     CMD_CLEAR: begin
                        valid_in[head_cmd.index] = 1'b0;
                     end
                     CMD_FAIL: begin
                        bad_in = 1'b1;
                     end
                     default: begin
                     end
                  endcase
                  if (head_cmd.last) begin
                     emit     = 1'b1;
                     emit_bad = bad_ff || (head_cmd.op == CMD_FAIL);
                  end
               end
            end
         end
         ST_SCAN: begin
            ram_rd      = 1'b1;
            rd_pend_in  = 1'b1;
            rd_valid_in = valid_ff[ptr_ff];
            if (ptr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               ptr_in   = '0;
               state_in = ST_WAIT;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!cur_ff.last || out_free) begin
               drop_in  = merged_drops;
               state_in = ST_IDLE;
               if (cur_ff.last) begin
                  emit       = 1'b1;
                  emit_drops = merged_drops;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // load the result register and clear the batch
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = emit_bad ? ALL_DROP_WORD : verdict_of(emit_drops);
         rsp_failed_in = emit_bad;
         drop_in       = '0;
         bad_in        = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         drop_ff      <= '0;
         bad_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rd_pend_ff   <= rd_pend_in;
         drop_ff      <= drop_in;
         bad_ff       <= bad_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rd_valid_ff   <= rd_valid_in;
      hit_ff        <= hit_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_verdict_word = rsp_word_ff;
   assign rsp_batch_failed = rsp_failed_ff;

`ifndef SYNTH
   // the settle cycle always follows the last scan read
   a_wait_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && !$past(reset)) |-> $past(state_ff) == ST_SCAN)
      else $error("settle cycle entered without a scan");

   // the scan pointer is parked at zero outside a scan
   a_ptr_parked: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> ptr_ff == '0)
      else $error("scan pointer not parked");

   // a delivered verdict leaves a clean batch and a full result register
   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      emit |=> (!bad_ff && drop_ff == '0 && rsp_valid_ff))
      else $error("batch state not cleared after verdict");

   // a result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result register overwritten");

   // the queue is popped only when it holds a command
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_status.empty && !(q_status.empty && q_status.full)))
      else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

### design/batched_five_tuple_acl_match.sv
// batched five-tuple acl: a packet with a good header passes through issue, a scan of every
// table entry (one rule compared per cycle through the rule store read port), settle and
// commit; rule writes, failed and ignored packets are handled in the idle state alone.
// synchronous reset clears the queue, batch state, result register and the
// per-rule valid bits at once; the rule stores are not cleared, no clearing pass.
`default_nettype none

module batched_five_tuple_acl_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [7:0]  req_rule_index,
   input  logic        req_rule_enable,
   input  logic [1:0]  req_slot,
   input  logic        req_last_of_batch,
   input  logic        req_header_complete,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_verdict_word,
   output logic        rsp_batch_failed
);

   import acl_pkg::*;

   cmd_type          front_cmd;
   cmd_type          head_cmd;
   queue_status_type q_status;
   logic             q_pop;

   // classify incoming items
   acl_front u_front (
      .req_kind            (req_kind),
      .req_rule_index      (req_rule_index),
      .req_rule_enable     (req_rule_enable),
      .req_slot            (req_slot),
      .req_last_of_batch   (req_last_of_batch),
      .req_header_complete (req_header_complete),
      .req_source_address  (req_source_address),
      .req_dest_address    (req_dest_address),
      .req_protocol        (req_protocol),
      .req_source_port     (req_source_port),
      .req_dest_port       (req_dest_port),
      .cmd                 (front_cmd)
   );

   // command queue
   acl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // rule table and scan
   acl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_pop          (pop),
      .rsp_empty        (empty),
      .rsp_verdict_word (rsp_verdict_word),
      .rsp_batch_failed (rsp_batch_failed)
   );

   assign full = q_status.full;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for batched_five_tuple_acl_match: directed and random items
// with a verdict predictor in a small class; depends on acl_pkg and the design top level
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import acl_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1725;
   localparam int PRESSURE_ITEMS = 14;
   localparam int HOLD_CYCLES    = 6000;
   localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int MAX_REPORTS    = 10;
   localparam int POOL_DEPTH     = 48;
   localparam logic [3:0] VERDICT_DROP = 4'h1;

   typedef enum bit {KIND_RULE = 1'b0, KIND_PACKET = 1'b1} item_kind_type;

   // the five header fields shared by rules and packets
   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [7:0]  protocol;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } flow_key_type;

   localparam int FLOW_W = $bits(flow_key_type);

   typedef struct {
      item_kind_type kind;
      logic [7:0]    rule_index;
      logic          rule_enable;
      logic [1:0]    slot;
      logic          last_of_batch;
      logic          header_complete;
      flow_key_type  flow;
   } acl_item_type;

   typedef struct {
      logic [15:0] verdict_word;
      logic        batch_failed;
   } batch_verdict_type;

   // rule table copy, open batch state and the verdicts still owed by the block
   class acl_verdict_book_type;
      logic [ADDR_KEY_W-1:0] address_keys [RULE_COUNT];
      logic [PP_KEY_W-1:0]   port_proto_keys [RULE_COUNT];
      bit                    rule_live [RULE_COUNT];
      logic [15:0]           open_verdicts;
      bit                    open_bad;
      batch_verdict_type     due_verdicts [$];
      int                    wrong_count;

      function new();
         foreach (rule_live[r]) rule_live[r] = 1'b0;
         open_verdicts = '0;
         open_bad = 1'b0;
         wrong_count = 0;
      endfunction

      function int outstanding();
         return due_verdicts.size();
      endfunction

      // update the table or the batch for one accepted item
      function void note_item(acl_item_type it);
         logic [ADDR_KEY_W-1:0] addr_key;
         logic [PP_KEY_W-1:0]   pp_key;
         bit                    hit;
         batch_verdict_type     closed;
         addr_key = {it.flow.source_address, it.flow.dest_address};
         pp_key = {it.flow.source_port, it.flow.dest_port, it.flow.protocol};
         if (it.kind == KIND_RULE) begin
            if (int'(it.rule_index) < RULE_COUNT) begin
               if (it.rule_enable) begin
                  address_keys[it.rule_index] = addr_key;
                  port_proto_keys[it.rule_index] = pp_key;
                  rule_live[it.rule_index] = 1'b1;
               end else begin
                  rule_live[it.rule_index] = 1'b0;
               end
            end
            return;
         end
         if (int'(it.slot) < BATCH_SLOTS) begin
            if (!it.header_complete ||
                (it.flow.protocol != PROTO_TCP && it.flow.protocol != PROTO_UDP)) begin
               open_bad = 1'b1;
            end else begin
               hit = 1'b0;
               for (int r = 0; r < RULE_COUNT; r++) begin
                  if (rule_live[r] && address_keys[r] == addr_key &&
                      port_proto_keys[r] == pp_key)
                     hit = 1'b1;
               end
               if (hit)
                  open_verdicts[4*it.slot +: 4] = open_verdicts[4*it.slot +: 4] | VERDICT_DROP;
            end
         end
         if (it.last_of_batch) begin
            closed.verdict_word = open_bad ? ALL_DROP_WORD : open_verdicts;
            closed.batch_failed = open_bad;
            due_verdicts.push_back(closed);
            open_verdicts = '0;
            open_bad = 1'b0;
         end
      endfunction

      function void flag(string what, logic [15:0] want, logic [15:0] got);
         wrong_count++;
         if (wrong_count <= MAX_REPORTS)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
      endfunction

      // compare one popped verdict with the oldest one owed
      function void check_verdict(logic [15:0] word, logic failed);
         batch_verdict_type want;
         if (due_verdicts.size() == 0) begin
            wrong_count++;
            if (wrong_count <= MAX_REPORTS)
               $display("%0t: verdict %h arrived with no batch closed", $time, word);
            return;
         end
         want = due_verdicts.pop_front();
         if (word !== want.verdict_word)
            flag("verdict_word", want.verdict_word, word);
         if (failed !== want.batch_failed)
            flag("batch_failed", 16'(want.batch_failed), 16'(failed));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rule_index = '0;
   logic        req_rule_enable = 1'b0;
   logic [1:0]  req_slot = '0;
   logic        req_last_of_batch = 1'b0;
   logic        req_header_complete = 1'b0;
   logic [31:0] req_source_address = '0;
   logic [31:0] req_dest_address = '0;
   logic [7:0]  req_protocol = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_dest_port = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [15:0] rsp_verdict_word;
   logic        rsp_batch_failed;

   bit                   hold_request = 1'b0;
   flow_key_type         rule_pool [$];
   acl_verdict_book_type book = new();

   batched_five_tuple_acl_match uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_kind            (req_kind),
      .req_rule_index      (req_rule_index),
      .req_rule_enable     (req_rule_enable),
      .req_slot            (req_slot),
      .req_last_of_batch   (req_last_of_batch),
      .req_header_complete (req_header_complete),
      .req_source_address  (req_source_address),
      .req_dest_address    (req_dest_address),
      .req_protocol        (req_protocol),
      .req_source_port     (req_source_port),
      .req_dest_port       (req_dest_port),
      .empty               (empty),
      .pop                 (pop),
      .rsp_verdict_word    (rsp_verdict_word),
      .rsp_batch_failed    (rsp_batch_failed)
   );

   always #HALF_PERIOD clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] pick_address();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [7:0] pick_protocol();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return PROTO_TCP;
      if (roll < 90) return PROTO_UDP;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic flow_key_type fresh_flow();
      flow_key_type f;
      f.source_address = pick_address();
      f.dest_address = pick_address();
      f.protocol = pick_protocol();
      f.source_port = pick_port();
      f.dest_port = pick_port();
      return f;
   endfunction

   // packets mostly reuse a stored rule, sometimes with one bit flipped
   function automatic flow_key_type pick_flow();
      flow_key_type f;
      if (rule_pool.size() != 0 && $urandom_range(0, 99) < 65) begin
         f = rule_pool[$urandom_range(0, rule_pool.size() - 1)];
         if ($urandom_range(0, 99) < 15)
            f = f ^ (FLOW_W'(1) << $urandom_range(0, FLOW_W - 1));
      end else begin
         f = fresh_flow();
      end
      return f;
   endfunction

   // fields a rule write ignores are left random
   function automatic acl_item_type make_rule(logic [7:0] index, logic enable,
                                              flow_key_type f);
      acl_item_type it;
      it.kind = KIND_RULE;
      it.rule_index = index;
      it.rule_enable = enable;
      it.slot = 2'($urandom_range(0, 3));
      it.last_of_batch = 1'($urandom_range(0, 1));
      it.header_complete = 1'($urandom_range(0, 1));
      it.flow = f;
      return it;
   endfunction

   function automatic acl_item_type make_packet(logic [1:0] slot, logic last, logic complete,
                                                flow_key_type f);
      acl_item_type it;
      it.kind = KIND_PACKET;
      it.rule_index = 8'($urandom_range(0, 255));
      it.rule_enable = 1'($urandom_range(0, 1));
      it.slot = slot;
      it.last_of_batch = last;
      it.header_complete = complete;
      it.flow = f;
      return it;
   endfunction

   function automatic acl_item_type random_item();
      acl_item_type it;
      flow_key_type f;
      logic [7:0] index;
      logic enable;
      if ($urandom_range(0, 99) < 25) begin
         // low indexes half the time so that entries get overwritten and cleared
         index = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
         enable = ($urandom_range(0, 99) < 85);
         f = fresh_flow();
         it = make_rule(index, enable, f);
         if (enable) begin
            rule_pool.push_back(f);
            if (rule_pool.size() > POOL_DEPTH) void'(rule_pool.pop_front());
         end
      end else begin
         it = make_packet(2'($urandom_range(0, 3)), $urandom_range(0, 99) < 30,
                          $urandom_range(0, 99) < 96, pick_flow());
      end
      return it;
   endfunction

   // offer one item, hold it until taken, then optionally idle
   task automatic send_item(input acl_item_type it, input int gap);
      @(negedge clock);
      push <= 1'b1;
      req_kind <= it.kind;
      req_rule_index <= it.rule_index;
      req_rule_enable <= it.rule_enable;
      req_slot <= it.slot;
      req_last_of_batch <= it.last_of_batch;
      req_header_complete <= it.header_complete;
      req_source_address <= it.flow.source_address;
      req_dest_address <= it.flow.dest_address;
      req_protocol <= it.flow.protocol;
      req_source_port <= it.flow.source_port;
      req_dest_port <= it.flow.dest_port;
      do @(posedge clock); while (full !== 1'b0);
      book.note_item(it);
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int stall_left;
      int calm_left;
      int roll;
      stall_left = 0;
      calm_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < 2)
                  calm_left = $urandom_range(50, 300);
               else if (roll < 25)
                  stall_left = pick_gap();
            end
         end
      end
   end

   // take each popped verdict
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         book.check_verdict(rsp_verdict_word, rsp_batch_failed);
   end

   // run limit
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus
   initial begin
      acl_item_type it;
      flow_key_type all_ones;
      flow_key_type all_zero;
      flow_key_type web_flow;
      flow_key_type variant;
      int calm_items;
      int gap;

      all_ones = '1;
      all_ones.protocol = PROTO_UDP;
      all_zero = '0;
      all_zero.protocol = PROTO_TCP;
      web_flow = {32'h0A00_0001, 32'hC0A8_0001, PROTO_TCP, 16'd1234, 16'd80};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lookup against an empty table
      send_item(make_packet(2'd0, 1'b1, 1'b1, all_ones), 0);

      // rules at both ends of the table, one written with batch fields set
      send_item(make_rule(8'd0, 1'b1, all_ones), 1);
      send_item(make_rule(8'd255, 1'b1, all_zero), 0);
      it = make_rule(8'd128, 1'b1, web_flow);
      it.last_of_batch = 1'b1;
      it.slot = 2'd3;
      it.header_complete = 1'b0;
      send_item(it, 2);

      // full batch with a near miss on the protocol in slot one
      send_item(make_packet(2'd0, 1'b0, 1'b1, all_ones), 0);
      variant = all_ones;
      variant.protocol = PROTO_TCP;
      send_item(make_packet(2'd1, 1'b0, 1'b1, variant), 0);
      send_item(make_packet(2'd2, 1'b0, 1'b1, all_zero), 3);
      send_item(make_packet(2'd3, 1'b1, 1'b1, web_flow), 0);

      // two rules matching the same packet
      send_item(make_rule(8'd1, 1'b1, all_ones), 0);
      send_item(make_packet(2'd1, 1'b1, 1'b1, all_ones), 0);

      // one slot given three times, only the first matches
      send_item(make_packet(2'd2, 1'b0, 1'b1, web_flow), 0);
      variant = all_zero;
      variant.dest_port = 16'd1;
      send_item(make_packet(2'd2, 1'b0, 1'b1, variant), 0);
      variant = all_zero;
      variant.source_port = 16'd1;
      send_item(make_packet(2'd2, 1'b1, 1'b1, variant), 0);

      // truncated header spoils the batch
      send_item(make_packet(2'd0, 1'b0, 1'b1, all_ones), 0);
      send_item(make_packet(2'd1, 1'b0, 1'b0, web_flow), 0);
      send_item(make_packet(2'd3, 1'b1, 1'b1, all_zero), 0);

      // protocol neither tcp nor udp
      variant = web_flow;
      variant.protocol = 8'hFF;
      send_item(make_packet(2'd0, 1'b1, 1'b1, variant), 0);
      variant = all_zero;
      variant.protocol = 8'h00;
      send_item(make_packet(2'd1, 1'b0, 1'b1, variant), 0);
      send_item(make_packet(2'd2, 1'b1, 1'b1, all_zero), 0);

      // cleared rules no longer match, clearing an unused entry too
      send_item(make_rule(8'd0, 1'b0, all_ones), 0);
      send_item(make_rule(8'd1, 1'b0, all_ones), 0);
      send_item(make_rule(8'd77, 1'b0, web_flow), 0);
      send_item(make_packet(2'd3, 1'b0, 1'b1, all_ones), 0);
      send_item(make_packet(2'd0, 1'b1, 1'b1, all_zero), 0);

      // back-to-back single-packet batches while the result side holds off
      hold_request = 1'b1;
      repeat (PRESSURE_ITEMS)
         send_item(make_packet(2'($urandom_range(0, 3)), 1'b1, $urandom_range(0, 3) != 0,
                               pick_flow()), 0);

      // random traffic with occasional stretches of no gaps
      calm_items = 0;
      repeat (RANDOM_ITEMS) begin
         if (calm_items > 0) begin
            calm_items--;
            gap = 0;
         end else if ($urandom_range(0, 99) < 3) begin
            calm_items = $urandom_range(20, 80);
            gap = 0;
         end else begin
            gap = pick_gap();
         end
         send_item(random_item(), gap);
      end
      @(negedge clock);
      push <= 1'b0;

      // drain
      while (book.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.wrong_count == 0 && book.outstanding() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
design/acl_pkg.sv
design/acl_ram.sv
design/acl_front.sv
design/acl_queue.sv
design/acl_back.sv
design/batched_five_tuple_acl_match.sv
tb/sv/testbench.sv
